FILE: sv/combination_enumerator_unit_macros.svh
// ----------------------------------------------------------------------------
// Combination enumerator assertion macros
// Shared concurrent-assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef COMBINATION_ENUMERATOR_UNIT_MACROS_SVH
`define COMBINATION_ENUMERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CEU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ceu_pkg.sv
// ----------------------------------------------------------------------------
// Combination enumerator package
// Field widths, register indexes and default sizes.
// ----------------------------------------------------------------------------
package ceu_pkg;

    localparam int MAX_SET_SIZE_DEF = 32;
    localparam int MAX_PICK_DEF     = 16;

    localparam int ELEM_W   = 6;
    localparam int SLOT_W   = 4;
    localparam int CIDX_W   = 30;
    localparam int SET_W    = 6;
    localparam int PICK_W   = 5;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'd1;

    localparam logic [SET_W-1:0]  SET_SIZE_RST   = 6'd5;
    localparam logic [PICK_W-1:0] PICK_COUNT_RST = 5'd3;

endpackage

FILE: sv/combination_enumerator_unit.sv
// Each beat takes a RAM read state, then an emit state that waits while the output
// is stalled; an advance first scans back from the rightmost stored element, reading
// and comparing each one. An exhausted beat leaves from its own state. o_stall holds
// off the input until the request's last beat is emitted, set by the single-port
// element RAM and its registered read.
// Synchronous reset (i_rst_n low) loads n=5, p=3 and idles; the RAM is not cleared.
// ----------------------------------------------------------------------------
// Combination enumerator unit
// Walks the p-subsets of {1..n} in lexicographic order, one element per beat,
// keeping the current combination in a small RAM updated read-modify-write.
// ----------------------------------------------------------------------------
module combination_enumerator_unit #(
    parameter int MAX_SET_SIZE = ceu_pkg::MAX_SET_SIZE_DEF,
    parameter int MAX_PICK     = ceu_pkg::MAX_PICK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ceu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ceu_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ceu_pkg::ELEM_W-1:0]    o_element,
    output logic [ceu_pkg::SLOT_W-1:0]    o_slot,
    output logic [ceu_pkg::CIDX_W-1:0]    o_combination_index,
    output logic                          o_last_in_combination,
    output logic                          o_final_combination,
    output logic                          o_exhausted
);
    import ceu_pkg::*;

    `include "combination_enumerator_unit_macros.svh"

    localparam int EW  = $clog2(MAX_SET_SIZE);
    localparam int NW  = $clog2(MAX_SET_SIZE + 1);
    localparam int AW  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int CW0 = (NW > AW + 1) ? NW : AW + 1;
    localparam int CW1 = (CW0 > SET_W) ? CW0 : SET_W;
    localparam int CW  = CW1 + 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CMP = 3'd2;
    localparam logic [2:0] ST_EMIT_RD  = 3'd3;
    localparam logic [2:0] ST_EMIT_OUT = 3'd4;
    localparam logic [2:0] ST_EXH      = 3'd5;

    logic [EW-1:0] mem [MAX_PICK];

    logic [2:0]        r_state, n_state;
    logic [SET_W-1:0]  r_set_size, n_set_size;
    logic [PICK_W-1:0] r_pick_count, n_pick_count;
    logic              r_started, n_started;
    logic              r_finished, n_finished;
    logic [CIDX_W-1:0] r_counter, n_counter;
    logic              r_ovalid, n_ovalid;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_s, n_s;
    logic [AW-1:0]     r_idx, n_idx;
    logic [EW-1:0]     r_base, n_base;
    logic              r_final, n_final;
    logic [ELEM_W-1:0] r_elem, n_elem;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CIDX_W-1:0] r_oidx, n_oidx;
    logic              r_olast, n_olast;
    logic              r_ofinal, n_ofinal;
    logic              r_oexh, n_oexh;
    logic [EW-1:0]     r_rd_data;

    logic          w_re, w_we;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [EW-1:0] w_wdata;

    logic [CW-1:0] w_n, w_p, w_nmp, w_bound, w_v, w_calc, w_val;
    logic [AW-1:0] w_pm1;
    logic          w_bad, w_fresh, w_accept, w_out_free, w_from_ram;

    always_comb begin
        w_n = (CW'(r_set_size) > CW'(MAX_SET_SIZE)) ? CW'(MAX_SET_SIZE)
                                                     : CW'(r_set_size);
        w_p        = CW'(r_pick_count);
        w_bad      = (w_p == '0) || (w_p > CW'(MAX_PICK)) || (w_p > w_n);
        w_pm1      = AW'(w_p - CW'(1));
        w_nmp      = w_n - w_p;
        w_bound    = w_nmp + CW'(r_ptr);
        w_v        = CW'(r_rd_data);
        w_calc     = CW'(r_base) + CW'(r_idx) - CW'(r_s);
        w_from_ram = r_idx < r_s;
        w_val      = w_from_ram ? w_v : w_calc;
        w_accept   = i_valid && (r_state == ST_IDLE);
        w_fresh    = i_restart || !r_started;
        w_out_free = !r_ovalid || !i_stall;
    end

    always_comb begin
        n_state      = r_state;
        n_set_size   = r_set_size;
        n_pick_count = r_pick_count;
        n_started    = r_started;
        n_finished   = r_finished;
        n_counter    = r_counter;
        n_ovalid     = r_ovalid && i_stall;
        n_ptr        = r_ptr;
        n_s          = r_s;
        n_idx        = r_idx;
        n_base       = r_base;
        n_final      = r_final;
        n_elem       = r_elem;
        n_slot       = r_slot;
        n_oidx       = r_oidx;
        n_olast      = r_olast;
        n_ofinal     = r_ofinal;
        n_oexh       = r_oexh;
        w_re         = 1'b0;
        w_raddr      = r_ptr;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = w_val[EW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_fresh) begin
                        n_started  = 1'b1;
                        n_finished = 1'b0;
                        n_counter  = '0;
                        if (w_bad) begin
                            n_state = ST_EXH;
                        end else begin
                            n_s     = '0;
                            n_idx   = '0;
                            n_base  = '0;
                            n_final = (w_n == w_p);
                            n_state = ST_EMIT_RD;
                        end
                    end else if (r_finished || w_bad) begin
                        n_state = ST_EXH;
                    end else begin
                        n_ptr   = w_pm1;
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                w_re    = 1'b1;
                w_raddr = r_ptr;
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (w_v < w_bound) begin
                    // rightmost element with room: raise it, refill the tail
                    n_s       = r_ptr;
                    n_base    = EW'(w_v + CW'(1));
                    // only a raised first element can land on the last subset
                    n_final   = (r_ptr == '0) && ((w_v + CW'(1)) == w_nmp);
                    n_counter = r_counter + CIDX_W'(1);
                    n_idx     = '0;
                    n_state   = ST_EMIT_RD;
                end else if (r_ptr == '0) begin
                    n_state = ST_EXH;
                end else begin
                    n_ptr   = r_ptr - AW'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                w_re    = w_from_ram;
                w_raddr = r_idx;
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (w_out_free) begin
                    w_we     = !w_from_ram;
                    n_ovalid = 1'b1;
                    n_elem   = ELEM_W'(w_val + CW'(1));
                    n_slot   = SLOT_W'(r_idx);
                    n_oidx   = r_counter;
                    n_olast  = (r_idx == w_pm1);
                    n_ofinal = r_final;
                    n_oexh   = 1'b0;
                    if (r_idx == w_pm1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_EXH: begin
                if (w_out_free) begin
                    n_finished = 1'b1;
                    n_ovalid   = 1'b1;
                    n_elem     = '0;
                    n_slot     = '0;
                    n_oidx     = '0;
                    n_olast    = 1'b1;
                    n_ofinal   = 1'b0;
                    n_oexh     = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SET_SIZE:   n_set_size   = i_cfg_data[SET_W-1:0];
                REG_PICK_COUNT: n_pick_count = i_cfg_data[PICK_W-1:0];
                default:        n_set_size   = r_set_size;
            endcase
            n_started  = 1'b0;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_set_size   <= SET_SIZE_RST;
            r_pick_count <= PICK_COUNT_RST;
            r_started    <= 1'b0;
            r_finished   <= 1'b0;
            r_counter    <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_set_size   <= n_set_size;
            r_pick_count <= n_pick_count;
            r_started    <= n_started;
            r_finished   <= n_finished;
            r_counter    <= n_counter;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_s      <= n_s;
        r_idx    <= n_idx;
        r_base   <= n_base;
        r_final  <= n_final;
        r_elem   <= n_elem;
        r_slot   <= n_slot;
        r_oidx   <= n_oidx;
        r_olast  <= n_olast;
        r_ofinal <= n_ofinal;
        r_oexh   <= n_oexh;
    end

    // element RAM: one write or one read per cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    assign o_stall               = (r_state != ST_IDLE);
    assign o_valid               = r_ovalid;
    assign o_element             = r_elem;
    assign o_slot                = r_slot;
    assign o_combination_index   = r_oidx;
    assign o_last_in_combination = r_olast;
    assign o_final_combination   = r_ofinal;
    assign o_exhausted           = r_oexh;

    `CEU_ASSERT_IMPLY(a_emit_in_range, (r_state == ST_EMIT_OUT), (CW'(r_idx) < w_p), "slot past pick count")
    `CEU_ASSERT_IMPLY(a_scan_live, (r_state == ST_SCAN_CMP), (r_started && !r_finished && !w_bad), "scan on a dead sequence")
    `CEU_ASSERT_IMPLY(a_final_not_exh, (r_ovalid && r_ofinal), (!r_oexh), "final flag on exhausted beat")
    `CEU_ASSERT_NEXT(a_stall_holds_idx, (r_state == ST_EMIT_OUT && r_ovalid && i_stall), ($stable(r_idx) && r_state == ST_EMIT_OUT), "emit advanced under stall")

endmodule

FILE: bench/tb_combination_enumerator_unit.sv
// ----------------------------------------------------------------------------
// Combination enumerator unit testbench
// Drives restart/next requests against a local lexicographic enumerator,
// matches every output beat field by field, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_combination_enumerator_unit;
    import ceu_pkg::*;

    localparam int  MAX_SET     = MAX_SET_SIZE_DEF;
    localparam int  MAX_PK      = MAX_PICK_DEF;
    localparam int  RANDOM_REQS = 350;
    localparam int  CALM_FROM   = 300;
    localparam int  DRAIN_WAIT  = 80;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [SLOT_W-1:0] slot;
        logic [CIDX_W-1:0] cidx;
        logic              last;
        logic              fin;
        logic              exh;
    } t_beat;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic                  restart;
        bit                    typed;
        t_beat                 want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_restart = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [ELEM_W-1:0]     o_element;
    logic [SLOT_W-1:0]     o_slot;
    logic [CIDX_W-1:0]     o_combination_index;
    logic                  o_last_in_combination;
    logic                  o_final_combination;
    logic                  o_exhausted;

    combination_enumerator_unit u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_restart             (i_restart),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_element             (o_element),
        .o_slot                (o_slot),
        .o_combination_index   (o_combination_index),
        .o_last_in_combination (o_last_in_combination),
        .o_final_combination   (o_final_combination),
        .o_exhausted           (o_exhausted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // enumerator state, mirrors the block
    logic [4:0]        pick_elems [0:MAX_PK-1];
    logic [CIDX_W-1:0] run_index;
    bit                begun;
    bit                spent;
    logic [SET_W-1:0]  set_reg;
    logic [PICK_W-1:0] pick_reg;

    t_beat step_beats[$];
    t_beat expected_beats[$];
    t_row  stim_rows[$];
    t_beat head_beat;
    int    fail_count;
    bit    calm;
    longint cycle_count;
    int    stall_left;

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        if (idx == REG_SET_SIZE) begin
            set_reg = data[SET_W-1:0];
        end else if (idx == REG_PICK_COUNT) begin
            pick_reg = data[PICK_W-1:0];
        end
        begun = 1'b0;
        spent = 1'b0;
    endfunction

    function automatic void emit_exhausted();
        t_beat b;
        spent = 1'b1;
        b = '0;
        b.last = 1'b1;
        b.exh = 1'b1;
        step_beats.push_back(b);
    endfunction

    function automatic void emit_combination(input int n, input int p);
        t_beat b;
        bit    at_end;
        int    i;
        at_end = 1'b1;
        for (i = 0; i < p; i++) begin
            if (int'(pick_elems[i]) != n - p + i) at_end = 1'b0;
        end
        for (i = 0; i < p; i++) begin
            b.element = ELEM_W'(pick_elems[i]) + 1'b1;
            b.slot = SLOT_W'(i);
            b.cidx = run_index;
            b.last = (i == p - 1);
            b.fin = at_end;
            b.exh = 1'b0;
            step_beats.push_back(b);
        end
    endfunction

    // lexicographic successor: bump the rightmost element with headroom, refill the tail
    function automatic void enumerate_next(input logic rs);
        int n, p, s, j;
        bit bad;
        step_beats.delete();
        n = (int'(set_reg) > MAX_SET) ? MAX_SET : int'(set_reg);
        p = int'(pick_reg);
        bad = (p == 0) || (p > MAX_PK) || (p > n);
        if (rs || !begun) begin
            begun = 1'b1;
            spent = 1'b0;
            run_index = '0;
            if (bad) begin
                emit_exhausted();
            end else begin
                for (j = 0; j < p; j++) pick_elems[j] = 5'(j);
                emit_combination(n, p);
            end
            return;
        end
        if (spent || bad) begin
            emit_exhausted();
            return;
        end
        for (s = p - 1; s >= 0; s--) begin
            if (int'(pick_elems[s]) < n - p + s) begin
                pick_elems[s] = pick_elems[s] + 1'b1;
                for (j = s + 1; j < p; j++) pick_elems[j] = pick_elems[s] + 5'(j - s);
                run_index = run_index + 1'b1;
                emit_combination(n, p);
                return;
            end
        end
        emit_exhausted();
    endfunction

    // valid goes low and we wait on the clock before returning, so no double drive in one step
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        load_register(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic issue(input logic rs, input bit typed, input t_beat want);
        int k;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        enumerate_next(rs);
        if (typed) begin
            expected_beats.push_back(want);
        end else begin
            for (k = 0; k < step_beats.size(); k++) expected_beats.push_back(step_beats[k]);
        end
        i_valid <= 1'b1;
        i_restart <= rs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
        t_row r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        r.restart = 1'b0;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endfunction

    // typed rows hold a single beat: slot 0, last set
    function automatic void add_req(input logic rs, input bit typed,
                                    input int elem, input int cidx,
                                    input bit fin, input bit exh);
        t_row r;
        r.kind = ROW_REQ;
        r.idx = '0;
        r.data = '0;
        r.restart = rs;
        r.typed = typed;
        r.want.element = ELEM_W'(elem);
        r.want.slot = '0;
        r.want.cidx = CIDX_W'(cidx);
        r.want.last = 1'b1;
        r.want.fin = fin;
        r.want.exh = exh;
        stim_rows.push_back(r);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: beat with nothing expected, expected none actual element %0d",
                         $time, o_element);
                fail_count++;
            end else begin
                head_beat = expected_beats.pop_front();
                check_field("element", head_beat.element, o_element);
                check_field("slot", head_beat.slot, o_slot);
                check_field("combination_index", head_beat.cidx, o_combination_index);
                check_field("last_in_combination", head_beat.last, o_last_in_combination);
                check_field("final_combination", head_beat.fin, o_final_combination);
                check_field("exhausted", head_beat.exh, o_exhausted);
            end
        end
    end

    // receiver stalls in random bursts with free stretches between
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 14);
        end else begin
            i_stall <= 1'b0;
            stall_left = $urandom_range(0, 30);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int    r, k, sent, nv, pv, neff, run_len;
        t_beat none;
        none = '0;
        fail_count = 0;
        calm = 1'b0;
        cycle_count = 0;
        stall_left = 0;
        run_index = '0;
        begun = 1'b0;
        spent = 1'b0;
        set_reg = SET_SIZE_RST;
        pick_reg = PICK_COUNT_RST;
        for (k = 0; k < MAX_PK; k++) pick_elems[k] = '0;

        // directed: reset sizes n=5 p=3 first
        add_req(1'b0, 0, 0, 0, 0, 0);          // next with nothing started acts as restart
        add_req(1'b0, 0, 0, 0, 0, 0);
        add_req(1'b1, 0, 0, 0, 0, 0);
        add_cfg(REG_SET_SIZE, 6'd3);           // p == n: one combination only
        add_req(1'b0, 0, 0, 0, 0, 0);
        add_req(1'b0, 1, 0, 0, 0, 1);
        add_req(1'b0, 1, 0, 0, 0, 1);          // stays exhausted
        add_cfg(REG_PICK_COUNT, 6'd1);
        add_req(1'b1, 1, 1, 0, 0, 0);
        add_req(1'b0, 0, 0, 0, 0, 0);
        add_req(1'b0, 1, 3, 2, 1, 0);
        add_req(1'b0, 1, 0, 0, 0, 1);
        add_cfg(REG_SET_SIZE, 6'd32);
        add_cfg(REG_PICK_COUNT, 6'd16);
        add_req(1'b1, 0, 0, 0, 0, 0);
        add_req(1'b0, 0, 0, 0, 0, 0);
        add_cfg(REG_PICK_COUNT, 6'd17);        // above max pick
        add_req(1'b0, 1, 0, 0, 0, 1);
        add_cfg(REG_PICK_COUNT, 6'd31);
        add_req(1'b1, 1, 0, 0, 0, 1);
        add_cfg(REG_SET_SIZE, 6'd63);          // saturates to max set size
        add_cfg(REG_PICK_COUNT, 6'd33);        // only low 5 bits kept: p=1
        add_req(1'b0, 1, 1, 0, 0, 0);
        add_cfg(REG_PICK_COUNT, 6'd0);
        add_req(1'b0, 1, 0, 0, 0, 1);
        add_cfg(REG_SET_SIZE, 6'd0);
        add_cfg(REG_PICK_COUNT, 6'd1);         // p > n
        add_req(1'b1, 1, 0, 0, 0, 1);
        add_cfg(REG_SET_SIZE, 6'd1);
        add_req(1'b0, 1, 1, 0, 1, 0);
        add_req(1'b0, 1, 0, 0, 0, 1);
        add_req(1'b1, 1, 1, 0, 1, 0);
        add_cfg(REG_SET_SIZE, 6'd16);
        add_cfg(REG_PICK_COUNT, 6'd16);
        add_req(1'b0, 0, 0, 0, 0, 0);
        add_req(1'b0, 1, 0, 0, 0, 1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_CFG) begin
                write_register(stim_rows[k].idx, stim_rows[k].data);
            end else begin
                issue(stim_rows[k].restart, stim_rows[k].typed, stim_rows[k].want);
            end
        end

        // random phases: new sizes, then a run of mostly next requests
        sent = 0;
        while (sent < RANDOM_REQS) begin
            r = $urandom_range(0, 19);
            if (r < 14) nv = $urandom_range(1, 10);
            else if (r < 17) nv = $urandom_range(11, 32);
            else nv = $urandom_range(33, 63);
            neff = (nv > MAX_SET) ? MAX_SET : nv;
            r = $urandom_range(0, 19);
            if (r < 15) pv = $urandom_range(1, (neff < 6) ? neff : 6);
            else if (r < 18) pv = $urandom_range(1, MAX_PK);
            else pv = $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 0) begin
                write_register(REG_SET_SIZE, CFG_W'(nv));
                write_register(REG_PICK_COUNT, CFG_W'(pv));
            end else begin
                write_register(REG_PICK_COUNT, CFG_W'(pv));
                write_register(REG_SET_SIZE, CFG_W'(nv));
            end
            run_len = $urandom_range(3, 30);
            for (k = 0; k < run_len && sent < RANDOM_REQS; k++) begin
                calm = (sent >= CALM_FROM);
                if (!calm && $urandom_range(0, 39) == 0) drain();
                issue($urandom_range(0, 11) == 0, 0, none);
                sent++;
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
